### hdl/pidc_pkg.sv
// Package with shared constants, codes and types of the positional PID controller.
package pidc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // The integrate band resets to 0.02 in the data format, rounded to nearest.
    localparam int BAND_NUM = 2;
    localparam int BAND_DEN = 100;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_DRIVE_UPPER    = 3'd4,
        CFG_DRIVE_LOWER    = 3'd5,
        CFG_INTEGRATE_BAND = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    // Per-stage control: load the stage, and whether the item is a clear.
    typedef struct packed {
        logic load;
        logic clear;
    } t_stage_ctl;

endpackage

### hdl/pidc_err.sv
// Error stage: saturated difference of setpoint and measurement.
module pidc_err
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measured,
    output logic signed [DATA_WIDTH-1:0] o_err
);

    localparam logic signed [DATA_WIDTH:0] DMAX = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH:0] DMIN = {2'b11, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH:0]   diff;
    logic signed [DATA_WIDTH-1:0] n_err;
    logic signed [DATA_WIDTH-1:0] r_err;

    always_comb begin
        diff = {i_setpoint[DATA_WIDTH-1], i_setpoint} - {i_measured[DATA_WIDTH-1], i_measured};
        if (diff > DMAX) begin
            n_err = DMAX[DATA_WIDTH-1:0];
        end else if (diff < DMIN) begin
            n_err = DMIN[DATA_WIDTH-1:0];
        end else begin
            n_err = diff[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err <= n_err;
        end
    end

    assign o_err = r_err;

endmodule

### hdl/pidc_integ.sv
// Integral stage: holds the integral and the last error, forms the error difference.
module pidc_integ
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_stage_ctl                   i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_err,
    input  logic        [DATA_WIDTH-2:0] i_integral_limit,
    input  logic        [DATA_WIDTH-2:0] i_integrate_band,
    output logic signed [DATA_WIDTH-1:0] o_err,
    output logic signed [DATA_WIDTH-1:0] o_integral,
    output logic signed [DATA_WIDTH:0]   o_delta
);

    logic signed [DATA_WIDTH-1:0] r_integral;
    logic signed [DATA_WIDTH-1:0] r_prev_err;
    logic signed [DATA_WIDTH-1:0] r_err_q;
    logic signed [DATA_WIDTH:0]   r_delta;

    logic signed [DATA_WIDTH:0]   err_x;
    logic signed [DATA_WIDTH:0]   mag;
    logic signed [DATA_WIDTH:0]   band_x;
    logic signed [DATA_WIDTH:0]   lim_x;
    logic signed [DATA_WIDTH:0]   lim_neg;
    logic signed [DATA_WIDTH:0]   sum;
    logic signed [DATA_WIDTH-1:0] n_integral;
    logic signed [DATA_WIDTH:0]   n_delta;

    always_comb begin
        err_x   = {i_err[DATA_WIDTH-1], i_err};
        mag     = i_err[DATA_WIDTH-1] ? -err_x : err_x;
        band_x  = {2'b00, i_integrate_band};
        lim_x   = {2'b00, i_integral_limit};
        lim_neg = -lim_x;
        sum     = {r_integral[DATA_WIDTH-1], r_integral} + err_x;
        n_integral = r_integral;
        // Anti-windup: accumulate only for small errors, then clamp symmetrically.
        if (mag < band_x) begin
            if (sum > lim_x) begin
                n_integral = lim_x[DATA_WIDTH-1:0];
            end else if (sum < lim_neg) begin
                n_integral = lim_neg[DATA_WIDTH-1:0];
            end else begin
                n_integral = sum[DATA_WIDTH-1:0];
            end
        end
        n_delta = err_x - {r_prev_err[DATA_WIDTH-1], r_prev_err};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_ctl.load) begin
            if (i_ctl.clear) begin
                r_integral <= '0;
                r_prev_err <= '0;
            end else begin
                r_integral <= n_integral;
                r_prev_err <= i_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_err_q <= i_err;
            r_delta <= n_delta;
        end
    end

    assign o_err      = r_err_q;
    assign o_integral = r_integral;
    assign o_delta    = r_delta;

endmodule

### hdl/pidc_mult.sv
// Multiply stage: the three gain products, each registered.
module pidc_mult
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic signed [DATA_WIDTH-1:0]   i_prop_gain,
    input  logic signed [DATA_WIDTH-1:0]   i_integ_gain,
    input  logic signed [DATA_WIDTH-1:0]   i_deriv_gain,
    input  logic signed [DATA_WIDTH-1:0]   i_err,
    input  logic signed [DATA_WIDTH-1:0]   i_integral,
    input  logic signed [DATA_WIDTH:0]     i_delta,
    output logic signed [2*DATA_WIDTH:0]   o_prop,
    output logic signed [2*DATA_WIDTH:0]   o_integ,
    output logic signed [2*DATA_WIDTH:0]   o_deriv
);

    localparam int PW = 2 * DATA_WIDTH + 1;

    logic signed [PW-1:0] r_prop;
    logic signed [PW-1:0] r_integ;
    logic signed [PW-1:0] r_deriv;
    logic signed [2*DATA_WIDTH-1:0] p_prop;
    logic signed [2*DATA_WIDTH-1:0] p_integ;
    logic signed [PW-1:0]           p_deriv;

    always_comb begin
        p_prop  = i_prop_gain * i_err;
        p_integ = i_integ_gain * i_integral;
        p_deriv = $signed({i_deriv_gain[DATA_WIDTH-1], i_deriv_gain}) * i_delta;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prop  <= {p_prop[2*DATA_WIDTH-1], p_prop};
            r_integ <= {p_integ[2*DATA_WIDTH-1], p_integ};
            r_deriv <= p_deriv;
        end
    end

    assign o_prop  = r_prop;
    assign o_integ = r_integ;
    assign o_deriv = r_deriv;

endmodule

### hdl/pidc_out.sv
// Output stage: sum, scale, saturate and clamp of the drive; a clear item drives zero.
module pidc_out
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_stage_ctl                   i_ctl,
    input  logic signed [2*DATA_WIDTH:0] i_prop,
    input  logic signed [2*DATA_WIDTH:0] i_integ,
    input  logic signed [2*DATA_WIDTH:0] i_deriv,
    input  logic signed [DATA_WIDTH-1:0] i_drive_upper,
    input  logic signed [DATA_WIDTH-1:0] i_drive_lower,
    output logic signed [DATA_WIDTH-1:0] o_drive
);

    localparam int SW = 2 * DATA_WIDTH + 3;
    localparam logic signed [SW-1:0] DMAX = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] DMIN = {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [SW-1:0]         sum;
    logic signed [SW-1:0]         scaled;
    logic signed [DATA_WIDTH-1:0] sat;
    logic signed [DATA_WIDTH-1:0] n_drive;
    logic signed [DATA_WIDTH-1:0] r_drive;

    always_comb begin
        sum = {{2{i_prop[2*DATA_WIDTH]}}, i_prop}
            + {{2{i_integ[2*DATA_WIDTH]}}, i_integ}
            + {{2{i_deriv[2*DATA_WIDTH]}}, i_deriv};
        // Arithmetic shift rounds toward minus infinity.
        scaled = sum >>> FRAC_BITS;
        if (scaled > DMAX) begin
            sat = DMAX[DATA_WIDTH-1:0];
        end else if (scaled < DMIN) begin
            sat = DMIN[DATA_WIDTH-1:0];
        end else begin
            sat = scaled[DATA_WIDTH-1:0];
        end
        n_drive = sat;
        if (n_drive > i_drive_upper) begin
            n_drive = i_drive_upper;
        end
        if (n_drive < i_drive_lower) begin
            n_drive = i_drive_lower;
        end
        if (i_ctl.clear) begin
            n_drive = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

### hdl/positional_pid_controller_core.sv
// Top level of the positional PID controller with anti-windup and its register file.
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  -----------------------------------
//  input    in         i_valid / o_stall          i_op, i_setpoint, i_measured
//  result   out        o_valid / i_stall          o_drive
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item is accepted every cycle while o_stall is low; its result becomes
// valid after the error, integral, multiply and output registers. The rate is
// set by the feedback of the integral and last-error registers in the integral
// stage, which every item reads and updates as it passes. The pipeline is input
// register, error, integral, multiply and output register. Reset clears the
// pipeline valids and the controller state and loads the register defaults. A
// stalled result freezes the whole pipeline, and o_stall then holds the input side.
module positional_pid_controller_core
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input items
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measured,
    // Result items
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    // Register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data
);

    // Band default is 0.02 in the fixed-point format, rounded to nearest.
    localparam logic [63:0] BAND_RESET_L =
        ((64'd1 << FRAC_BITS) * BAND_NUM * 2 + BAND_DEN) / (BAND_DEN * 2);
    localparam logic [DATA_WIDTH-2:0] BAND_RESET = BAND_RESET_L[DATA_WIDTH-2:0];
    localparam logic [DATA_WIDTH-2:0] LIMIT_RESET = {(DATA_WIDTH-1){1'b1}};
    localparam logic signed [DATA_WIDTH-1:0] UPPER_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] LOWER_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic signed [DATA_WIDTH-1:0] r_prop_gain;
    logic signed [DATA_WIDTH-1:0] r_integ_gain;
    logic signed [DATA_WIDTH-1:0] r_deriv_gain;
    logic        [DATA_WIDTH-2:0] r_integral_limit;
    logic signed [DATA_WIDTH-1:0] r_drive_upper;
    logic signed [DATA_WIDTH-1:0] r_drive_lower;
    logic        [DATA_WIDTH-2:0] r_integrate_band;

    // Pipeline control: one valid bit per stage, one op bit per stage before the output register.
    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic r_op0, r_op1, r_op2, r_op3;
    logic advance;
    logic accept;

    // Input register payload.
    logic signed [DATA_WIDTH-1:0] r_setpoint;
    logic signed [DATA_WIDTH-1:0] r_measured;

    // Inter-stage data.
    logic signed [DATA_WIDTH-1:0] err_s1;
    logic signed [DATA_WIDTH-1:0] err_s2;
    logic signed [DATA_WIDTH-1:0] integral_s2;
    logic signed [DATA_WIDTH:0]   delta_s2;
    logic signed [2*DATA_WIDTH:0] prop_s3;
    logic signed [2*DATA_WIDTH:0] integ_s3;
    logic signed [2*DATA_WIDTH:0] deriv_s3;

    t_stage_ctl integ_ctl;
    t_stage_ctl out_ctl;

    // The pipeline moves as a whole whenever the output register is free or
    // its item is being taken this cycle.
    assign advance = !r_vo || !i_stall;
    assign o_stall = !advance;
    assign accept  = i_valid && advance;
    assign o_valid = r_vo;

    // Writes are to be issued only while the block is idle; the block does not enforce this and takes every write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= '0;
            r_integ_gain     <= '0;
            r_deriv_gain     <= '0;
            r_integral_limit <= LIMIT_RESET;
            r_drive_upper    <= UPPER_RESET;
            r_drive_lower    <= LOWER_RESET;
            r_integrate_band <= BAND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:      r_prop_gain      <= i_cfg_data;
                CFG_INTEG_GAIN:     r_integ_gain     <= i_cfg_data;
                CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg_data;
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[DATA_WIDTH-2:0];
                CFG_DRIVE_UPPER:    r_drive_upper    <= i_cfg_data;
                CFG_DRIVE_LOWER:    r_drive_lower    <= i_cfg_data;
                CFG_INTEGRATE_BAND: r_integrate_band <= i_cfg_data[DATA_WIDTH-2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (advance) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    // Op bits and input payload carry no reset; the valids qualify them.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_op1 <= r_op0;
            r_op2 <= r_op1;
            r_op3 <= r_op2;
        end
        if (accept) begin
            r_op0      <= i_op;
            r_setpoint <= i_setpoint;
            r_measured <= i_measured;
        end
    end

    pidc_err #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_err (
        .i_clk      (i_clk),
        .i_load     (advance && r_v0),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .o_err      (err_s1)
    );

    // The integral stage is the only one that touches controller state, so it
    // must load exactly once per item.
    assign integ_ctl.load  = advance && r_v1;
    assign integ_ctl.clear = (r_op1 == OP_CLEAR);

    pidc_integ #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_integ (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (integ_ctl),
        .i_err            (err_s1),
        .i_integral_limit (r_integral_limit),
        .i_integrate_band (r_integrate_band),
        .o_err            (err_s2),
        .o_integral       (integral_s2),
        .o_delta          (delta_s2)
    );

    pidc_mult #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mult (
        .i_clk        (i_clk),
        .i_load       (advance && r_v2),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .i_err        (err_s2),
        .i_integral   (integral_s2),
        .i_delta      (delta_s2),
        .o_prop       (prop_s3),
        .o_integ      (integ_s3),
        .o_deriv      (deriv_s3)
    );

    // A clear item reports a drive of zero.
    assign out_ctl.load  = advance && r_v3;
    assign out_ctl.clear = (r_op3 == OP_CLEAR);

    pidc_out #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_ctl         (out_ctl),
        .i_prop        (prop_s3),
        .i_integ       (integ_s3),
        .i_deriv       (deriv_s3),
        .i_drive_upper (r_drive_upper),
        .i_drive_lower (r_drive_lower),
        .o_drive       (o_drive)
    );

endmodule

### test/tb.sv
// Self-checking testbench for the positional PID controller core.
`timescale 1ns / 100ps

module tb
    import pidc_pkg::*;
();

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;

    // Saturation bounds of the signed data range.
    localparam longint DATA_MAX = 64'sd2147483647;
    localparam longint DATA_MIN = -64'sd2147483648;

    // After the last expected result has come back, the bench waits this many more
    // edges before the block is taken to be idle.
    localparam int SETTLE_CYCLES = 8;

    // Each side idles in this many cycles out of a hundred while gaps are on.
    localparam int IDLE_PCT = 37;

    localparam int MAX_REPORTS = 10;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_op        = OP_STEP;
    logic signed [DW-1:0] i_setpoint  = '0;
    logic signed [DW-1:0] i_measured  = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic signed [DW-1:0] o_drive;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DW-1:0]        i_cfg_data  = '0;

    positional_pid_controller_core #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive     (o_drive),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The shadow copy of the controller: its registers and its state, kept in
    // step with every register write and every accepted item.
    logic signed [DW-1:0] kp, ki, kd, drv_hi, drv_lo;
    logic [DW-2:0]        int_limit, band;
    logic signed [DW-1:0] ctl_integral, ctl_last_err;

    // Drive values still owed by the block, oldest first.
    logic signed [DW-1:0] drive_expect_q[$];

    int  mismatch_cnt = 0;
    bit  src_gaps     = 1'b0;
    bit  sink_stalls  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A generous ceiling: the slowest correct run needs only a few tens of
    // microseconds.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Register values right after reset.
    task automatic reset_shadow();
        kp           = '0;
        ki           = '0;
        kd           = '0;
        int_limit    = '1;
        drv_hi       = DATA_MAX[DW-1:0];
        drv_lo       = DATA_MIN[DW-1:0];
        band         = 31'd1311;
        ctl_integral = '0;
        ctl_last_err = '0;
    endtask

    function automatic void shadow_write(t_cfg_idx idx, logic [DW-1:0] data);
        case (idx)
            CFG_PROP_GAIN:      kp = data;
            CFG_INTEG_GAIN:     ki = data;
            CFG_DERIV_GAIN:     kd = data;
            CFG_INTEGRAL_LIMIT: int_limit = data[DW-2:0];
            CFG_DRIVE_UPPER:    drv_hi = data;
            CFG_DRIVE_LOWER:    drv_lo = data;
            CFG_INTEGRATE_BAND: band = data[DW-2:0];
            default: ;
        endcase
    endfunction

    // Advances the shadow state by one item and returns the drive it yields.
    // The three products are summed in a wide signed accumulator, so the
    // arithmetic shift below floors exactly as the Q32.32 sum would.
    function automatic logic signed [DW-1:0] pid_drive_next(t_op op,
                                                            logic signed [DW-1:0] sp,
                                                            logic signed [DW-1:0] meas);
        longint               diff, integ, lim, drv;
        logic signed [DW-1:0] err;
        logic signed [79:0]   p_term, i_term, d_term, acc;
        if (op == OP_CLEAR) begin
            ctl_integral = '0;
            ctl_last_err = '0;
            return '0;
        end
        diff = longint'(sp) - longint'(meas);
        if (diff > DATA_MAX) diff = DATA_MAX;
        if (diff < DATA_MIN) diff = DATA_MIN;
        err = diff[DW-1:0];

        // Anti-windup: only errors inside the band reach the integral, and
        // an out-of-band step leaves it untouched, even if above the limit.
        if ((diff < 0 ? -diff : diff) < longint'(band)) begin
            integ = longint'(ctl_integral) + diff;
            lim   = longint'(int_limit);
            if (integ > lim)  integ = lim;
            if (integ < -lim) integ = -lim;
            ctl_integral = integ[DW-1:0];
        end

        p_term = kp * err;
        i_term = ki * ctl_integral;
        d_term = kd * (err - ctl_last_err);
        acc    = (p_term + i_term + d_term) >>> FB;
        if (acc > DATA_MAX)      drv = DATA_MAX;
        else if (acc < DATA_MIN) drv = DATA_MIN;
        else                     drv = longint'($signed(acc[DW-1:0]));

        // The lower clamp comes last, so it wins when the limits cross.
        if (drv > longint'(drv_hi)) drv = longint'(drv_hi);
        if (drv < longint'(drv_lo)) drv = longint'(drv_lo);
        ctl_last_err = err;
        return drv[DW-1:0];
    endfunction

    // The receiving side stalls at random while stalls are enabled.
    always @(posedge i_clk) begin
        i_stall <= sink_stalls && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Every accepted result is checked against the oldest expected drive.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result item: drive %0d", o_drive);
                end
            end else begin
                if (o_drive !== drive_expect_q[0]) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("drive mismatch: expected %0d, actual %0d",
                                 drive_expect_q[0], o_drive);
                    end
                end
                void'(drive_expect_q.pop_front());
            end
        end
    end

    // Offers one item, with a random gap in front of it, and books the
    // expected drive at the edge that accepts it. Valid is not lowered here,
    // so back-to-back items keep it high.
    task automatic send_item(t_op op, logic signed [DW-1:0] sp,
                             logic signed [DW-1:0] meas);
        while (src_gaps && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_setpoint <= sp;
        i_measured <= meas;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        drive_expect_q.push_back(pid_drive_next(op, sp, meas));
    endtask

    // Holds the input side until every expected result has come back, then
    // lets the pipeline settle so that registers may be written safely.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_write(idx, data);
    endtask

    // Writes the whole register file while the block is idle.
    task automatic load_settings(logic signed [DW-1:0] p, logic signed [DW-1:0] i,
                                 logic signed [DW-1:0] d, logic [DW-2:0] lim,
                                 logic signed [DW-1:0] hi, logic signed [DW-1:0] lo,
                                 logic [DW-2:0] bnd);
        wait_idle();
        cfg_write(CFG_PROP_GAIN, p);
        cfg_write(CFG_INTEG_GAIN, i);
        cfg_write(CFG_DERIV_GAIN, d);
        cfg_write(CFG_INTEGRAL_LIMIT, {1'b0, lim});
        cfg_write(CFG_DRIVE_UPPER, hi);
        cfg_write(CFG_DRIVE_LOWER, lo);
        cfg_write(CFG_INTEGRATE_BAND, {1'b0, bnd});
        i_cfg_valid <= 1'b0;
    endtask

    // With all gains at zero after reset, every drive is zero.
    task automatic test_reset_defaults();
        send_item(OP_STEP, 32'sh0005_0000, 32'sh0002_0000);
        send_item(OP_CLEAR, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    // Errors at the ends of the range saturate before the gains apply.
    task automatic test_error_saturation();
        load_settings(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, '1,
                      DATA_MAX[DW-1:0], DATA_MIN[DW-1:0], 31'd1311);
        send_item(OP_STEP, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_STEP, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_STEP, 32'sh0000_0000, 32'sh0000_0000);
        send_item(OP_STEP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(OP_STEP, 32'sh8000_0000, 32'sh8000_0000);
    endtask

    // The integral grows only inside the band, stops at the band edge itself,
    // saturates at both signs of the limit and is zeroed by a clear.
    task automatic test_anti_windup();
        load_settings(32'sh0, 32'sh0001_0000, 32'sh0, 31'd1500,
                      DATA_MAX[DW-1:0], DATA_MIN[DW-1:0], 31'd1000);
        send_item(OP_STEP, 32'sd999, 32'sd0);
        send_item(OP_STEP, 32'sd999, 32'sd0);
        send_item(OP_STEP, 32'sd1000, 32'sd0);
        send_item(OP_STEP, -32'sd1000, 32'sd0);
        repeat (4) send_item(OP_STEP, 32'sd0, 32'sd999);
        send_item(OP_CLEAR, 32'sd0, 32'sd0);
        send_item(OP_STEP, 32'sd7, 32'sd0);
    endtask

    // Crossed drive limits, flooring of small negative sums, and gains at
    // their extremes.
    task automatic test_clamp_and_rounding();
        load_settings(32'sd1, 32'sh0, 32'sh8000_0000, '1, -32'sd100, 32'sd100, 31'd1311);
        send_item(OP_STEP, 32'sd0, 32'sd3);
        load_settings(32'sd1, 32'sh0, 32'sh0, '1,
                      DATA_MAX[DW-1:0], DATA_MIN[DW-1:0], 31'd1311);
        send_item(OP_STEP, 32'sd0, 32'sd3);
        send_item(OP_STEP, 32'sd3, 32'sd0);
        load_settings(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd0,
                      DATA_MAX[DW-1:0], DATA_MIN[DW-1:0], '1);
        send_item(OP_STEP, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    function automatic logic signed [DW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return DATA_MAX[DW-1:0];
            1:       return DATA_MIN[DW-1:0];
            2:       return '0;
            5:       return $urandom;
            default: return int'($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
        endcase
    endfunction

    // Phases of random settings, each followed by random items. Half the items
    // keep the error near or inside the band so that the integral actually
    // moves; the rest are full-range values, range ends and small values. Clears are mixed in at random.
    task automatic test_random_phases(int phases, int items_per_phase);
        logic [DW-2:0]        lim, bnd;
        logic [DW-1:0]        rnd;
        logic signed [DW-1:0] hi, lo, sp, meas;
        int                   span, delta, pick;
        t_op                  op;
        for (int ph = 0; ph < phases; ph++) begin
            case ($urandom_range(0, 3))
                0:       lim = '1;
                1:       lim = '0;
                2: begin
                    rnd = $urandom_range(0, 200000);
                    lim = rnd[DW-2:0];
                end
                default: begin
                    rnd = $urandom;
                    lim = rnd[DW-2:0];
                end
            endcase
            case ($urandom_range(0, 3))
                0:       bnd = '0;
                1:       bnd = '1;
                2: begin
                    rnd = $urandom_range(1, 5000);
                    bnd = rnd[DW-2:0];
                end
                default: begin
                    rnd = $urandom;
                    bnd = rnd[DW-2:0];
                end
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    hi = DATA_MAX[DW-1:0];
                    lo = DATA_MIN[DW-1:0];
                end
                1: begin
                    hi = $urandom;
                    lo = $urandom;
                end
                2: begin
                    hi = $urandom_range(0, 32'h10_0000);
                    lo = -int'($urandom_range(0, 32'h10_0000));
                end
                default: begin
                    lo = $urandom_range(0, 32'h10_0000);
                    hi = -int'($urandom_range(0, 32'h10_0000));
                end
            endcase
            load_settings(pick_gain(), pick_gain(), pick_gain(), lim, hi, lo, bnd);

            // The first phase runs with both sides at full speed throughout.
            src_gaps    = (ph != 0);
            sink_stalls = (ph != 0);

            span = (bnd > 31'd100000) ? 100000 : int'(bnd);
            for (int n = 0; n < items_per_phase; n++) begin
                op   = ($urandom_range(0, 99) < 4) ? OP_CLEAR : OP_STEP;
                pick = $urandom_range(0, 99);
                sp   = $urandom;
                if (pick < 50) begin
                    delta = int'($urandom_range(0, 2 * span + 2)) - (span + 1);
                    meas  = sp - delta;
                end else if (pick < 80) begin
                    meas = $urandom;
                end else if (pick < 90) begin
                    sp   = $urandom_range(0, 1) ? DATA_MAX[DW-1:0] : DATA_MIN[DW-1:0];
                    meas = $urandom_range(0, 1) ? DATA_MAX[DW-1:0] : DATA_MIN[DW-1:0];
                end else begin
                    sp   = int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
                    meas = int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
                end
                send_item(op, sp, meas);
            end
        end
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_error_saturation();
        test_anti_windup();
        test_clamp_and_rounding();
        test_random_phases(11, 100);

        wait_idle();
        if (mismatch_cnt == 0 && drive_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### positional_pid_controller_core.f
hdl/pidc_pkg.sv
hdl/pidc_err.sv
hdl/pidc_integ.sv
hdl/pidc_mult.sv
hdl/pidc_out.sv
hdl/positional_pid_controller_core.sv
test/tb.sv
